FILE: rtl/polynomial_arithmetic_unit_assert.svh
// Assertion macros for the polynomial arithmetic unit.
`ifndef POLYNOMIAL_ARITHMETIC_UNIT_ASSERT_SVH
`define POLYNOMIAL_ARITHMETIC_UNIT_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define PAU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define PAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pau_pkg.sv
// ----------------------------------------------------------------------------
// pau_pkg
// Types and constants of the polynomial arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package pau_pkg;
	localparam int MaxTerms = 16;
	localparam int WorkLen = 2 * MaxTerms - 1;
	localparam int CntW = $clog2(MaxTerms + 1);
	localparam int IdxW = $clog2(MaxTerms);
	localparam int WIdxW = $clog2(WorkLen);

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY_QUOT = 3'd1,
		ST_ZERO_LEAD = 3'd2,
		ST_EMPTY_OPND = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CHECK,
		S_CLEAR,
		S_ADD,
		S_MUL_RD,
		S_MUL_WR,
		S_DIV_LEAD,
		S_DIV_CHK,
		S_DIV_RUN,
		S_DIV_SUB,
		S_DIV_WR,
		S_OUT_RD,
		S_OUT,
		S_ERR
	} state_t;

	typedef struct packed {
		logic        target_poly;
		logic [31:0] coeff_value;
		logic        final_coeff;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_coeff;
		logic [4:0]  term_index;
		logic        last_result;
		logic [2:0]  status;
	} out_item_t;
endpackage
`default_nettype wire

FILE: rtl/polynomial_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// polynomial_arithmetic_unit
// Polynomial add, subtract, multiply and long-division quotient.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one coefficient per transfer,
// appended to A or B; the transfer marked final starts the job.
// Output channel (out_valid/out_ready/out_data): result coefficients lowest
// degree first, last one marked; errors give one item with a status code.
// After the final transfer the operands are checked and the work memory is
// cleared, then the add/sub, multiply or divide step runs and each result
// is read from the work memory. No input is taken during a job.
// A stall on the output holds the current result; the sequencer waits.
// Reset clears counts, flags, op_mode and the sequencer; the coefficient
// memories are not cleared. The op_mode register sits at APB address 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polynomial_arithmetic_unit_assert.svh"
module polynomial_arithmetic_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire pau_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output pau_pkg::out_item_t      out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [1:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import pau_pkg::*;

	logic [31:0] mem_a [MaxTerms];
	logic [31:0] mem_b [MaxTerms];
	logic [31:0] mem_w [WorkLen];

	logic [1:0]       mode_q;
	logic [CntW-1:0]  cnt_a_q, cnt_b_q;
	logic             ovf_q;
	state_t           state_q, state_d;
	logic [CntW-1:0]  i_q, j_q, n_q;
	logic [31:0]      rd_a_s1, rd_b_s1, rd_w_s1;
	logic [31:0]      lead_q, quo_q;
	logic             out_valid_q;
	out_item_t        out_q;
	logic             div_start, div_done;
	logic [31:0]      div_quo;

	logic [IdxW-1:0]  ra_addr, rb_addr;
	logic [WIdxW-1:0] rw_addr, ww_addr;
	logic             ww_en;
	logic [31:0]      ww_data;
	logic [31:0]      prod;
	logic             in_fire, out_fire;
	logic [CntW-1:0]  i_m1, k_base;
	logic [31:0]      add_a, add_b;

	// Division keeps the remainder in store A, rewritten in place.
	logic             a_wr_en;
	logic [IdxW-1:0]  a_wr_addr;
	logic [31:0]      a_wr_data;
	logic             sub_ph_q;

	assign pready = 1'b1;
	assign prdata = {30'd0, mode_q};
	assign in_ready = (state_q == S_LOAD);
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_fire = out_valid_q && out_ready;
	assign i_m1 = i_q - 1'b1;
	assign k_base = i_q - cnt_b_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ADD;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			mode_q <= pwdata[1:0];
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (in_fire && !in_data.target_poly && cnt_a_q < CntW'(MaxTerms))
			mem_a[cnt_a_q[IdxW-1:0]] <= in_data.coeff_value;
		else if (a_wr_en)
			mem_a[a_wr_addr] <= a_wr_data;
		if (in_fire && in_data.target_poly && cnt_b_q < CntW'(MaxTerms))
			mem_b[cnt_b_q[IdxW-1:0]] <= in_data.coeff_value;
		if (ww_en)
			mem_w[ww_addr] <= ww_data;
		rd_a_s1 <= mem_a[ra_addr];
		rd_b_s1 <= mem_b[rb_addr];
		rd_w_s1 <= mem_w[rw_addr];
	end

	assign prod = 32'(rd_a_s1 * rd_b_s1);
	assign add_a = (i_m1 < cnt_a_q) ? rd_a_s1 : 32'd0;
	assign add_b = (i_m1 < cnt_b_q) ? rd_b_s1 : 32'd0;

	pau_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(rd_a_s1), .divisor(lead_q),
		.done(div_done), .quotient(div_quo)
	);

	// address and write control
	always_comb begin
		ra_addr = i_q[IdxW-1:0];
		rb_addr = j_q[IdxW-1:0];
		rw_addr = WIdxW'(i_q + j_q);
		ww_en = 1'b0;
		ww_addr = WIdxW'(i_q + j_q);
		ww_data = '0;
		div_start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				ww_en = 1'b1;
				ww_addr = WIdxW'(i_q);
			end
			S_ADD: begin
				ww_en = (i_q != '0);
				ww_addr = WIdxW'(i_m1);
				ww_data = (mode_q == MODE_ADD) ? add_a + add_b : add_a - add_b;
			end
			S_MUL_WR: begin
				ww_en = 1'b1;
				ww_data = rd_w_s1 + prod;
			end
			S_DIV_LEAD: begin
				rb_addr = IdxW'(cnt_b_q - 1'b1);
			end
			S_DIV_RUN: begin
				// i_q = k+db: read rem[k+db] (kept in store A)
				div_start = !sub_ph_q;
			end
			S_DIV_SUB: begin
				ra_addr = IdxW'(k_base + j_q);
			end
			S_DIV_WR: begin
				ww_en = 1'b1;
				ww_addr = WIdxW'(k_base);
				ww_data = quo_q;
				ra_addr = IdxW'(i_m1);
			end
			S_OUT_RD: begin
				rw_addr = WIdxW'(i_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		a_wr_en = (state_q == S_DIV_SUB) && sub_ph_q;
		a_wr_addr = IdxW'(k_base + j_q - 1'b1);
		a_wr_data = rd_a_s1 - 32'(quo_q * rd_b_s1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: if (in_fire && in_data.final_coeff) state_d = S_CHECK;
			S_CHECK: state_d = (ovf_q || cnt_a_q == '0 || cnt_b_q == '0) ? S_ERR : S_CLEAR;
			S_CLEAR: if (i_q == CntW'(WorkLen - 1) || i_q == '1) begin
				case (mode_q)
					MODE_ADD, MODE_SUB: state_d = S_ADD;
					MODE_MUL: state_d = S_MUL_RD;
					default: state_d = S_DIV_LEAD;
				endcase
			end
			S_ADD: if (i_q == n_q) state_d = S_OUT_RD;
			S_MUL_RD: state_d = S_MUL_WR;
			S_MUL_WR: if (i_q == cnt_a_q - 1'b1 && j_q == cnt_b_q - 1'b1)
				state_d = S_OUT_RD; else state_d = S_MUL_RD;
			S_DIV_LEAD: state_d = S_DIV_CHK;
			S_DIV_CHK: state_d = (rd_b_s1 == '0 || cnt_a_q < cnt_b_q) ? S_ERR : S_DIV_RUN;
			S_DIV_RUN: if (div_done) state_d = S_DIV_SUB;
			S_DIV_SUB: if (sub_ph_q && j_q == cnt_b_q) state_d = S_DIV_WR;
			S_DIV_WR: state_d = (i_q == cnt_b_q - 1'b1) ? S_OUT_RD : S_DIV_RUN;
			S_OUT_RD: state_d = S_OUT;
			S_OUT: if (!out_valid_q || out_ready) begin
				if (out_valid_q && out_q.last_result) state_d = S_LOAD;
				else if (out_valid_q) state_d = S_OUT_RD;
			end
			S_ERR: if (out_valid_q && out_ready) state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
			sub_ph_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_fire) out_valid_q <= 1'b0;
			case (state_q)
				S_LOAD: if (in_fire) begin
					if (!in_data.target_poly) begin
						if (cnt_a_q < CntW'(MaxTerms)) cnt_a_q <= cnt_a_q + 1'b1;
						else ovf_q <= 1'b1;
					end else begin
						if (cnt_b_q < CntW'(MaxTerms)) cnt_b_q <= cnt_b_q + 1'b1;
						else ovf_q <= 1'b1;
					end
					i_q <= '0;
					j_q <= '0;
				end
				S_CHECK: begin
					if (ovf_q || cnt_a_q == '0 || cnt_b_q == '0) begin
						out_valid_q <= 1'b1;
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						ovf_q <= 1'b0;
					end
					i_q <= '0;
				end
				S_CLEAR: begin
					if (state_d != S_CLEAR) begin
						i_q <= '0;
						j_q <= '0;
						n_q <= (cnt_a_q > cnt_b_q) ? cnt_a_q : cnt_b_q;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_ADD: begin
					if (state_d != S_ADD) begin
						i_q <= '0;
						j_q <= '0;
					end else begin
						i_q <= i_q + 1'b1;
						j_q <= j_q + 1'b1;
					end
				end
				S_MUL_WR: begin
					if (state_d == S_OUT_RD) begin
						n_q <= cnt_a_q + cnt_b_q - 1'b1;
						i_q <= '0;
						j_q <= '0;
					end else if (j_q == cnt_b_q - 1'b1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DIV_LEAD: begin
					n_q <= cnt_a_q - cnt_b_q + 1'b1;
					i_q <= cnt_a_q - 1'b1;
					j_q <= '0;
				end
				S_DIV_CHK: begin
					if (rd_b_s1 == '0 || cnt_a_q < cnt_b_q) begin
						out_valid_q <= 1'b1;
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						ovf_q <= 1'b0;
					end
					sub_ph_q <= 1'b0;
				end
				S_DIV_RUN: begin
					j_q <= '0;
					sub_ph_q <= !div_done;
				end
				S_DIV_SUB: begin
					sub_ph_q <= 1'b1;
					if (state_d == S_DIV_SUB) j_q <= j_q + 1'b1;
				end
				S_DIV_WR: begin
					if (state_d == S_OUT_RD) i_q <= '0;
					else i_q <= i_q - 1'b1;
					j_q <= '0;
					sub_ph_q <= 1'b0;
				end
				S_OUT_RD: ;
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						i_q <= i_q + 1'b1;
					end else if (out_ready && out_q.last_result) begin
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CHECK: begin
				out_q.result_coeff <= '0;
				out_q.term_index <= '0;
				out_q.last_result <= 1'b1;
				out_q.status <= ovf_q ? ST_OVERFLOW : ST_EMPTY_OPND;
			end
			S_DIV_CHK: begin
				lead_q <= rd_b_s1;
				out_q.result_coeff <= '0;
				out_q.term_index <= '0;
				out_q.last_result <= 1'b1;
				out_q.status <= (rd_b_s1 == '0) ? ST_ZERO_LEAD : ST_EMPTY_QUOT;
			end
			S_DIV_SUB: if (!sub_ph_q) quo_q <= div_quo;
			S_OUT: if (!out_valid_q) begin
				out_q.result_coeff <= rd_w_s1;
				out_q.term_index <= 5'(i_q);
				out_q.last_result <= (i_q + 1'b1 == n_q);
				out_q.status <= ST_OK;
			end
			default: ;
		endcase
	end

	`PAU_ASSERT_IMP(a_no_load_busy, clk, arst_n, state_q != S_LOAD, !in_ready, "input taken mid-job")
	`PAU_ASSERT_IMP(a_cnt_a_bound, clk, arst_n, 1'b1, cnt_a_q <= CntW'(MaxTerms), "count A overrun")
	`PAU_ASSERT_IMP(a_cnt_b_bound, clk, arst_n, 1'b1, cnt_b_q <= CntW'(MaxTerms), "count B overrun")
	`PAU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
endmodule
`default_nettype wire

FILE: rtl/pau_div.sv
// ----------------------------------------------------------------------------
// pau_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none
module pau_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	import pau_pkg::*;

	logic [31:0] rem_q, quo_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (~dividend + 32'd1) : dividend;
			dvs_q <= divisor[31] ? (~divisor + 32'd1) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (~quo_q + 32'd1) : quo_q;
endmodule
`default_nettype wire
